### rtl/rbsi_pkg.sv
// ----------------------------------------------------------------------------
// rbsi_pkg: shared types and constants for the ray / box slab test
// Payload structs, lane result type and configuration register indexes.
// ----------------------------------------------------------------------------
package rbsi_pkg;

   localparam int COORD_WIDTH   = 32;
   localparam int FRAC_BITS_DEF = 16;
   localparam int LEN_WIDTH     = COORD_WIDTH - 1;
   localparam int NUM_LANES     = 3;
   localparam int CSR_IDX_WIDTH = 3;

   // configuration register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_BOX_MIN_X = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_BOX_MIN_Y = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_BOX_MIN_Z = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_BOX_MAX_X = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_BOX_MAX_Y = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_BOX_MAX_Z = 3'd5;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] origin_x;
      logic signed [COORD_WIDTH-1:0] origin_y;
      logic signed [COORD_WIDTH-1:0] origin_z;
      logic signed [COORD_WIDTH-1:0] dir_x;
      logic signed [COORD_WIDTH-1:0] dir_y;
      logic signed [COORD_WIDTH-1:0] dir_z;
      logic        [LEN_WIDTH-1:0]   ray_length;
   } req_type;

   typedef struct packed {
      logic                 hit;
      logic [LEN_WIDTH-1:0] t_entry;
   } rsp_type;

   typedef struct packed {
      logic                          miss;
      logic signed [COORD_WIDTH-1:0] near;
      logic signed [COORD_WIDTH-1:0] far;
   } lane_res_type;

endpackage

### rtl/rbsi_div.sv
// ----------------------------------------------------------------------------
// rbsi_div: pipelined signed fixed point divider
// (num << FRAC_BITS) / den truncated toward zero, saturated, one bit a stage.
// ----------------------------------------------------------------------------
module rbsi_div #(
   parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic signed [rbsi_pkg::COORD_WIDTH+1:0] num,
   input  logic signed [rbsi_pkg::COORD_WIDTH-1:0] den,
   output logic signed [rbsi_pkg::COORD_WIDTH-1:0] quo
);
   localparam int CW   = rbsi_pkg::COORD_WIDTH;
   localparam int NUMW = CW + 2;
   localparam int NW   = CW + 1;
   localparam int DVW  = NW + FRAC_BITS;
   localparam int TOPW = DVW - CW;
   localparam int CMPW = (TOPW > CW) ? TOPW : CW;
   localparam int RW   = CW + 1;

   logic [NW-1:0] mag_n_ff;
   logic [CW-1:0] mag_d_ff;
   logic          neg_m_ff;

   logic [NUMW-1:0] num_abs;
   logic [CW-1:0]   den_abs;

   assign num_abs = num[NUMW-1] ? NUMW'(-num) : NUMW'(num);
   assign den_abs = den[CW-1] ? (~den + 1'b1) : den;

   always_ff @(posedge clock) begin
      mag_n_ff <= num_abs[NW-1:0];
      mag_d_ff <= den_abs;
      neg_m_ff <= num[NUMW-1] ^ den[CW-1];
   end

   logic [DVW-1:0] dvd;
   logic [TOPW-1:0] top;
   logic           ovf;

   assign dvd = {mag_n_ff, {FRAC_BITS{1'b0}}};
   assign top = dvd[DVW-1:CW];
   // quotient cannot fit CW bits when the high part already reaches the divisor
   assign ovf = CMPW'(top) >= CMPW'(mag_d_ff);

   logic [RW-1:0] r_ff   [CW];
   logic [CW-1:0] q_ff   [CW];
   logic [CW-1:0] low_ff [CW];
   logic [CW-1:0] d_ff   [CW];
   logic          neg_ff [CW];
   logic          ovf_ff [CW];

   genvar s;
   generate
      for (s = 0; s < CW; s++) begin : g_step
         logic [RW-1:0] r_prev;
         logic [CW-1:0] q_prev;
         logic [CW-1:0] low_prev;
         logic [CW-1:0] d_prev;
         logic          neg_prev;
         logic          ovf_prev;
         logic [RW-1:0] trial;
         logic          ge;

         if (s == 0) begin : g_first
            assign r_prev   = RW'(top);
            assign q_prev   = '0;
            assign low_prev = dvd[CW-1:0];
            assign d_prev   = mag_d_ff;
            assign neg_prev = neg_m_ff;
            assign ovf_prev = ovf;
         end else begin : g_next
            assign r_prev   = r_ff[s-1];
            assign q_prev   = q_ff[s-1];
            assign low_prev = low_ff[s-1];
            assign d_prev   = d_ff[s-1];
            assign neg_prev = neg_ff[s-1];
            assign ovf_prev = ovf_ff[s-1];
         end

         assign trial = {r_prev[RW-2:0], low_prev[CW-1-s]};
         assign ge    = trial >= {1'b0, d_prev};

         always_ff @(posedge clock) begin
            r_ff[s]   <= ge ? (trial - {1'b0, d_prev}) : trial;
            q_ff[s]   <= q_prev | (CW'(ge) << (CW-1-s));
            low_ff[s] <= low_prev;
            d_ff[s]   <= d_prev;
            neg_ff[s] <= neg_prev;
            ovf_ff[s] <= ovf_prev;
         end
      end
   endgenerate

   logic [CW-1:0] qf;
   logic          big;
   logic signed [CW-1:0] quo_in;
   logic signed [CW-1:0] quo_ff;

   assign qf  = q_ff[CW-1];
   assign big = ovf_ff[CW-1] | qf[CW-1];

   always_comb begin
      if (neg_ff[CW-1]) begin
         quo_in = big ? {1'b1, {(CW-1){1'b0}}} : (~qf + 1'b1);
      end else begin
         quo_in = big ? {1'b0, {(CW-1){1'b1}}} : qf;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
   end

   assign quo = quo_ff;

endmodule

### rtl/rbsi_lane.sv
// ----------------------------------------------------------------------------
// rbsi_lane: slab test of one axis
// Slab numerators, two dividers, and near / far with the per-axis miss flag.
// ----------------------------------------------------------------------------
module rbsi_lane #(
   parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic signed [rbsi_pkg::COORD_WIDTH-1:0] origin,
   input  logic signed [rbsi_pkg::COORD_WIDTH-1:0] dir,
   input  logic signed [rbsi_pkg::COORD_WIDTH-1:0] box_lo,
   input  logic signed [rbsi_pkg::COORD_WIDTH-1:0] box_hi,
   output rbsi_pkg::lane_res_type                  res
);
   localparam int CW   = rbsi_pkg::COORD_WIDTH;
   localparam int NUMW = CW + 2;
   localparam int DL   = CW + 2;
   localparam logic [63:0] EPS = ((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000;
   localparam logic signed [NUMW-1:0] EPS_S = NUMW'(EPS);

   logic signed [NUMW-1:0] num0_ff;
   logic signed [NUMW-1:0] num1_ff;
   logic signed [CW-1:0]   dir_ff;
   logic                   zero_ff;
   logic                   zmiss_ff;

   logic signed [NUMW-1:0] o_x;
   logic signed [NUMW-1:0] lo_x;
   logic signed [NUMW-1:0] hi_x;

   assign o_x  = NUMW'(origin);
   assign lo_x = NUMW'(box_lo);
   assign hi_x = NUMW'(box_hi);

   always_ff @(posedge clock) begin
      num0_ff  <= (lo_x - EPS_S) - o_x;
      num1_ff  <= (hi_x + EPS_S) - o_x;
      dir_ff   <= dir;
      zero_ff  <= (dir == '0);
      zmiss_ff <= (origin < box_lo) || (origin > box_hi);
   end

   logic signed [CW-1:0] t0;
   logic signed [CW-1:0] t1;

   rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_lo (
      .clock (clock),
      .num   (num0_ff),
      .den   (dir_ff),
      .quo   (t0)
   );

   rbsi_div #(.FRAC_BITS(FRAC_BITS)) u_div_hi (
      .clock (clock),
      .num   (num1_ff),
      .den   (dir_ff),
      .quo   (t1)
   );

   // zero-direction flags ride alongside the dividers
   logic zero_dly_ff  [DL];
   logic zmiss_dly_ff [DL];

   always_ff @(posedge clock) begin
      zero_dly_ff[0]  <= zero_ff;
      zmiss_dly_ff[0] <= zmiss_ff;
      for (int i = 1; i < DL; i++) begin
         zero_dly_ff[i]  <= zero_dly_ff[i-1];
         zmiss_dly_ff[i] <= zmiss_dly_ff[i-1];
      end
   end

   rbsi_pkg::lane_res_type res_in;
   rbsi_pkg::lane_res_type res_ff;

   always_comb begin
      if (zero_dly_ff[DL-1]) begin
         // axis does not constrain the interval
         res_in.miss = zmiss_dly_ff[DL-1];
         res_in.near = {1'b1, {(CW-1){1'b0}}};
         res_in.far  = {1'b0, {(CW-1){1'b1}}};
      end else begin
         res_in.miss = t0[CW-1] & t1[CW-1];
         res_in.near = (t0 < t1) ? t0 : t1;
         res_in.far  = (t0 < t1) ? t1 : t0;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign res = res_ff;

endmodule

### rtl/rbsi_merge.sv
// ----------------------------------------------------------------------------
// rbsi_merge: combines the three axis lanes
// Interval intersection, length check and entry clamp, two register stages.
// ----------------------------------------------------------------------------
module rbsi_merge (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   input  rbsi_pkg::lane_res_type               lane_res [rbsi_pkg::NUM_LANES],
   input  logic [rbsi_pkg::LEN_WIDTH-1:0]       len,
   output logic                                 out_strobe,
   output rbsi_pkg::rsp_type                    out_data
);
   localparam int CW = rbsi_pkg::COORD_WIDTH;
   localparam int LW = rbsi_pkg::LEN_WIDTH;

   logic                 v1_ff;
   logic                 miss1_ff;
   logic signed [CW-1:0] tlo_ff;
   logic signed [CW-1:0] thi_ff;
   logic [LW-1:0]        len1_ff;

   logic                 miss_in;
   logic signed [CW-1:0] tlo_in;
   logic signed [CW-1:0] thi_in;

   always_comb begin
      miss_in = 1'b0;
      tlo_in  = lane_res[0].near;
      thi_in  = lane_res[0].far;
      for (int i = 0; i < rbsi_pkg::NUM_LANES; i++) begin
         miss_in = miss_in | lane_res[i].miss;
         if (lane_res[i].near > tlo_in) begin
            tlo_in = lane_res[i].near;
         end
         if (lane_res[i].far < thi_in) begin
            thi_in = lane_res[i].far;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
      end
      miss1_ff <= miss_in;
      tlo_ff   <= tlo_in;
      thi_ff   <= thi_in;
      len1_ff  <= len;
   end

   logic                 hit_in;
   logic signed [CW-1:0] len_x;
   rbsi_pkg::rsp_type    rsp_in;
   rbsi_pkg::rsp_type    rsp_ff;
   logic                 v2_ff;

   assign len_x  = {1'b0, len1_ff};
   assign hit_in = !miss1_ff && !(tlo_ff > thi_ff) && !(tlo_ff > len_x);

   always_comb begin
      rsp_in.hit     = hit_in;
      rsp_in.t_entry = (hit_in && tlo_ff > 0) ? tlo_ff[LW-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      rsp_ff <= rsp_in;
   end

   assign out_strobe = v2_ff;
   assign out_data   = rsp_ff;

endmodule

### rtl/ray_box_slab_intersect.sv
// ----------------------------------------------------------------------------
// ray_box_slab_intersect: ray against axis-aligned box, slab test
// Three axis lanes with pipelined dividers and a merging stage.
// ----------------------------------------------------------------------------
//   channel  ports                               direction
//   request  start, busy, req_data               in
//   result   rsp_strobe, rsp_data                out
//   csr      csr_valid, csr_ready, csr_index,    in
//            csr_wdata
//
// one ray per cycle; each result reaches the result ports through the lane input
// registers, the one-bit-per-stage divider pipelines and the merge registers.
// busy is always low and csr_ready always high; results cannot be stalled.
// synchronous reset clears the pipeline valid bits and the box registers.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect #(
   parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  rbsi_pkg::req_type                      req_data,
   output logic                                   rsp_strobe,
   output rbsi_pkg::rsp_type                      rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [rbsi_pkg::CSR_IDX_WIDTH-1:0]     csr_index,
   input  logic signed [rbsi_pkg::COORD_WIDTH-1:0] csr_wdata
);
   localparam int CW = rbsi_pkg::COORD_WIDTH;
   localparam int LW = rbsi_pkg::LEN_WIDTH;
   localparam int NL = rbsi_pkg::NUM_LANES;
   localparam int LL = CW + 4;

   logic signed [CW-1:0] box_lo_ff [NL];
   logic signed [CW-1:0] box_hi_ff [NL];

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NL; i++) begin
            box_lo_ff[i] <= '0;
            box_hi_ff[i] <= '0;
         end
      end else if (csr_valid) begin
         case (csr_index)
            rbsi_pkg::CSR_BOX_MIN_X: begin
               box_lo_ff[0] <= csr_wdata;
            end
            rbsi_pkg::CSR_BOX_MIN_Y: begin
               box_lo_ff[1] <= csr_wdata;
            end
            rbsi_pkg::CSR_BOX_MIN_Z: begin
               box_lo_ff[2] <= csr_wdata;
            end
            rbsi_pkg::CSR_BOX_MAX_X: begin
               box_hi_ff[0] <= csr_wdata;
            end
            rbsi_pkg::CSR_BOX_MAX_Y: begin
               box_hi_ff[1] <= csr_wdata;
            end
            rbsi_pkg::CSR_BOX_MAX_Z: begin
               box_hi_ff[2] <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   logic                 accept;
   logic signed [CW-1:0] origin [NL];
   logic signed [CW-1:0] dir    [NL];

   assign accept    = start & ~busy;
   assign origin[0] = req_data.origin_x;
   assign origin[1] = req_data.origin_y;
   assign origin[2] = req_data.origin_z;
   assign dir[0]    = req_data.dir_x;
   assign dir[1]    = req_data.dir_y;
   assign dir[2]    = req_data.dir_z;

   rbsi_pkg::lane_res_type lane_res [NL];

   genvar a;
   generate
      for (a = 0; a < NL; a++) begin : g_lane
         rbsi_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .clock  (clock),
            .origin (origin[a]),
            .dir    (dir[a]),
            .box_lo (box_lo_ff[a]),
            .box_hi (box_hi_ff[a]),
            .res    (lane_res[a])
         );
      end
   endgenerate

   // transfer marker and ray length follow the lanes
   logic          vld_ff [LL];
   logic [LW-1:0] len_ff [LL];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LL; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= accept;
         for (int i = 1; i < LL; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
      len_ff[0] <= req_data.ray_length;
      for (int i = 1; i < LL; i++) begin
         len_ff[i] <= len_ff[i-1];
      end
   end

   rbsi_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (vld_ff[LL-1]),
      .lane_res   (lane_res),
      .len        (len_ff[LL-1]),
      .out_strobe (rsp_strobe),
      .out_data   (rsp_data)
   );

endmodule

### tb/sv/ray_box_slab_intersect_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_tb: self-checking bench for the ray / box slab test
// Rays are sent through the command channel against several box settings.
// Each result is checked against a local fixed-point slab predictor.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect_tb;
   import rbsi_pkg::*;

   localparam int     FRAC    = FRAC_BITS_DEF;
   localparam longint EPS     = ((longint'(1) << FRAC) + 5000) / 10000;
   localparam longint SAT_HI  = (longint'(1) << (COORD_WIDTH - 1)) - 1;
   localparam longint SAT_LO  = -(longint'(1) << (COORD_WIDTH - 1));
   localparam int     LATENCY = COORD_WIDTH + 6;
   localparam int     WD_LIMIT = 2000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   req_type           req_data = '0;
   logic              rsp_strobe;
   rsp_type           rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [CSR_IDX_WIDTH-1:0] csr_index = '0;
   logic signed [COORD_WIDTH-1:0] csr_wdata = '0;

   ray_box_slab_intersect dut (.*);

   initial forever #5 clock = ~clock;

   longint  box_lo[3];
   longint  box_hi[3];
   rsp_type pending_hits[$];
   int      errors = 0;
   int      rays_sent = 0;
   int      hits_seen = 0;
   int      idle_cycles = 0;
   bit      gaps_on = 1'b1;

   // signed fixed-point quotient, truncated toward zero and saturated
   function automatic longint slab_div(longint num, longint den);
      bit     neg;
      longint n, d, q, r;
      neg = (num < 0) != (den < 0);
      n = num < 0 ? -num : num;
      d = den < 0 ? -den : den;
      q = n / d;
      r = n % d;
      for (int i = 0; i < FRAC && q <= -SAT_LO; i++) begin
         q = q << 1;
         r = r << 1;
         if (r >= d) begin
            r = r - d;
            q = q | 1;
         end
      end
      if (neg) return (q >= -SAT_LO) ? SAT_LO : -q;
      return (q > SAT_HI) ? SAT_HI : q;
   endfunction

   function automatic rsp_type slab_hit(req_type ray);
      longint  org[3], dir[3];
      longint  t_lo, t_hi, t0, t1, near_t, far_t, len;
      bit      hit;
      rsp_type res;
      org[0] = ray.origin_x; org[1] = ray.origin_y; org[2] = ray.origin_z;
      dir[0] = ray.dir_x;    dir[1] = ray.dir_y;    dir[2] = ray.dir_z;
      t_lo = -(longint'(1) << 62);
      t_hi = longint'(1) << 62;
      len = longint'(ray.ray_length);
      hit = 1'b1;
      for (int i = 0; i < 3 && hit; i++) begin
         if (dir[i] == 0) begin
            if (org[i] < box_lo[i] || org[i] > box_hi[i]) hit = 1'b0;
            continue;
         end
         t0 = slab_div((box_lo[i] - EPS) - org[i], dir[i]);
         t1 = slab_div((box_hi[i] + EPS) - org[i], dir[i]);
         if (t0 < 0 && t1 < 0) begin
            hit = 1'b0;
            continue;
         end
         near_t = t0 < t1 ? t0 : t1;
         far_t  = t0 < t1 ? t1 : t0;
         if (near_t > t_lo) t_lo = near_t;
         if (far_t < t_hi) t_hi = far_t;
         if (t_lo > t_hi || t_lo > len) hit = 1'b0;
      end
      res.hit = hit;
      res.t_entry = (hit && t_lo > 0) ? t_lo[LEN_WIDTH-1:0] : '0;
      return res;
   endfunction

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_hits.size() == 0) begin
            $error("unexpected result hit=%0d t_entry=%0d", rsp_data.hit, rsp_data.t_entry);
            errors++;
         end else begin
            rsp_type want;
            want = pending_hits.pop_front();
            if (rsp_data.hit !== want.hit) begin
               $error("hit: expected %0d actual %0d", want.hit, rsp_data.hit);
               errors++;
            end
            if (rsp_data.t_entry !== want.t_entry) begin
               $error("t_entry: expected %0d actual %0d", want.t_entry, rsp_data.t_entry);
               errors++;
            end
            if (want.hit) hits_seen++;
         end
      end
   end

   // watchdog on cycles with no transfer of any kind
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", WD_LIMIT);
         $display("ray_box_slab_intersect regression: fail");
         $finish;
      end
   end

   task automatic send_ray(req_type ray);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= ray;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_hits = {pending_hits, slab_hit(ray)};
      rays_sent++;
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_WIDTH-1:0] idx, longint value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[COORD_WIDTH-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_BOX_MIN_X: box_lo[0] = longint'(signed'(value[COORD_WIDTH-1:0]));
         CSR_BOX_MIN_Y: box_lo[1] = longint'(signed'(value[COORD_WIDTH-1:0]));
         CSR_BOX_MIN_Z: box_lo[2] = longint'(signed'(value[COORD_WIDTH-1:0]));
         CSR_BOX_MAX_X: box_hi[0] = longint'(signed'(value[COORD_WIDTH-1:0]));
         CSR_BOX_MAX_Y: box_hi[1] = longint'(signed'(value[COORD_WIDTH-1:0]));
         CSR_BOX_MAX_Z: box_hi[2] = longint'(signed'(value[COORD_WIDTH-1:0]));
         default: ;
      endcase
   endtask

   task automatic set_box(longint lx, longint ly, longint lz,
                          longint hx, longint hy, longint hz);
      drain();
      write_csr(CSR_BOX_MIN_X, lx);
      write_csr(CSR_BOX_MIN_Y, ly);
      write_csr(CSR_BOX_MIN_Z, lz);
      write_csr(CSR_BOX_MAX_X, hx);
      write_csr(CSR_BOX_MAX_Y, hy);
      write_csr(CSR_BOX_MAX_Z, hz);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [COORD_WIDTH-1:0] rand_coord(int span);
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return ($urandom_range(0, 1) ? SAT_HI : SAT_LO) + $urandom_range(0, 3)
                   - $urandom_range(0, 3);
         2: return '0;
         default: return $signed($urandom_range(0, 2 * span)) - span;
      endcase
   endfunction

   function automatic req_type rand_ray(int span);
      req_type ray;
      ray.origin_x = rand_coord(span);
      ray.origin_y = rand_coord(span);
      ray.origin_z = rand_coord(span);
      ray.dir_x = rand_coord(span / 4);
      ray.dir_y = rand_coord(span / 4);
      ray.dir_z = rand_coord(span / 4);
      case ($urandom_range(0, 3))
         0: ray.ray_length = $urandom();
         1: ray.ray_length = $urandom_range(0, 16) << FRAC;
         2: ray.ray_length = '1;
         default: ray.ray_length = $urandom_range(0, 1 << 20);
      endcase
      return ray;
   endfunction

   // aim a ray at a point inside the current box so most rays reach the merge
   function automatic req_type aimed_ray(int span);
      req_type ray;
      longint  tgt[3], org[3], d[3];
      ray = rand_ray(span);
      for (int i = 0; i < 3; i++) begin
         tgt[i] = box_lo[i] + ((box_hi[i] - box_lo[i]) * $urandom_range(0, 100)) / 100;
         org[i] = tgt[i] + $signed($urandom_range(0, 2 * span)) - span;
         d[i] = (tgt[i] - org[i]) / 4;
         if ($urandom_range(0, 7) == 0) d[i] = 0;
      end
      ray.origin_x = org[0]; ray.origin_y = org[1]; ray.origin_z = org[2];
      ray.dir_x = d[0]; ray.dir_y = d[1]; ray.dir_z = d[2];
      return ray;
   endfunction

   task automatic test_reset_box();
      req_type ray;
      // box is a single point at the origin after reset
      ray = '0;
      send_ray(ray);
      ray.dir_x = 32'sd1 <<< FRAC;
      ray.origin_x = -(32'sd4 <<< FRAC);
      ray.ray_length = '1;
      send_ray(ray);
      ray.origin_y = 32'sd1;
      send_ray(ray);
   endtask

   task automatic test_directed();
      req_type ray;
      set_box(-(1 << FRAC), -(1 << FRAC), -(1 << FRAC), 1 << FRAC, 1 << FRAC, 1 << FRAC);
      // all directions zero, origin inside then outside
      ray = '0;
      send_ray(ray);
      ray.origin_z = (2 << FRAC);
      send_ray(ray);
      // axial hit with unlimited length, length at the entry distance, and zero length
      ray = '0;
      ray.origin_x = -(5 << FRAC);
      ray.dir_x = 1 << FRAC;
      ray.ray_length = '1;
      send_ray(ray);
      ray.ray_length = 4 << FRAC;
      send_ray(ray);
      ray.ray_length = 0;
      send_ray(ray);
      // pointing away: both distances negative
      ray.dir_x = -(1 << FRAC);
      ray.ray_length = '1;
      send_ray(ray);
      // origin on the face widened by the margin: entry distance is exactly zero
      ray.origin_x = -(1 << FRAC) - EPS;
      ray.dir_x = 32'h7fffffff;
      send_ray(ray);
      // tiny direction forces saturation
      ray.origin_x = -(100 << FRAC);
      ray.dir_x = 1;
      send_ray(ray);
      ray.dir_x = -1;
      ray.origin_x = 100 << FRAC;
      send_ray(ray);
      // extremes of every field
      ray.origin_x = 32'h80000000; ray.origin_y = 32'h7fffffff; ray.origin_z = 32'h80000000;
      ray.dir_x = 32'h7fffffff; ray.dir_y = 32'h80000000; ray.dir_z = 32'h7fffffff;
      send_ray(ray);
      ray.dir_x = 32'h80000000; ray.dir_y = 32'h7fffffff; ray.dir_z = 32'h80000000;
      ray.origin_x = 32'h7fffffff; ray.origin_y = 32'h80000000; ray.origin_z = 32'h7fffffff;
      send_ray(ray);
      ray = '1;
      send_ray(ray);
      // diagonal miss: interval becomes empty
      ray = '0;
      ray.origin_x = -(3 << FRAC); ray.origin_y = 3 << FRAC;
      ray.dir_x = 1 << FRAC; ray.dir_y = 1 << FRAC;
      ray.ray_length = '1;
      send_ray(ray);
      // inverted box
      set_box(1 << FRAC, 1 << FRAC, 1 << FRAC, -(1 << FRAC), -(1 << FRAC), -(1 << FRAC));
      ray = '0;
      send_ray(ray);
      ray.dir_x = 1 << FRAC; ray.origin_x = -(4 << FRAC);
      ray.ray_length = '1;
      send_ray(ray);
   endtask

   task automatic test_random_box(int count, int span);
      for (int n = 0; n < count; n++)
         send_ray($urandom_range(0, 3) == 0 ? rand_ray(span) : aimed_ray(span));
   endtask

   task automatic test_random();
      int lo[3], sz[3];
      // widest box first, then a batch of random boxes and single-point boxes at the extremes
      set_box(SAT_LO, SAT_LO, SAT_LO, SAT_HI, SAT_HI, SAT_HI);
      test_random_box(150, 1 << 30);
      for (int b = 0; b < 8; b++) begin
         for (int i = 0; i < 3; i++) begin
            lo[i] = $signed($urandom_range(0, 64 << FRAC)) - (32 << FRAC);
            sz[i] = $urandom_range(0, 16 << FRAC);
         end
         set_box(lo[0], lo[1], lo[2], lo[0] + sz[0], lo[1] + sz[1], lo[2] + sz[2]);
         test_random_box(200, 40 << FRAC);
      end
      set_box(SAT_HI, SAT_HI, SAT_HI, SAT_HI, SAT_HI, SAT_HI);
      test_random_box(50, 1 << 30);
      set_box(SAT_LO, SAT_LO, SAT_LO, SAT_LO, SAT_LO, SAT_LO);
      test_random_box(50, 1 << 30);
      // back to back with no gaps to close out
      set_box(-(8 << FRAC), -(8 << FRAC), -(8 << FRAC), 8 << FRAC, 8 << FRAC, 8 << FRAC);
      gaps_on = 1'b0;
      test_random_box(100, 24 << FRAC);
   endtask

   initial begin
      for (int i = 0; i < 3; i++) begin
         box_lo[i] = 0;
         box_hi[i] = 0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_box();
      test_directed();
      test_random();
      drain();
      $display("covered %0d rays over directed, random and extreme boxes", rays_sent);
      $display("%0d hits checked, %0d failures", hits_seen, errors);
      if (errors == 0)
         $display("ray_box_slab_intersect regression: pass");
      else
         $display("ray_box_slab_intersect regression: fail");
      $finish;
   end

endmodule

### files.f
rtl/rbsi_pkg.sv
rtl/rbsi_div.sv
rtl/rbsi_lane.sv
rtl/rbsi_merge.sv
rtl/ray_box_slab_intersect.sv
tb/sv/ray_box_slab_intersect_tb.sv
